/* rtl/core/btm_pkg.sv */
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types and codes for the byte tape machine: request and response
// transactions, request and status codes, instruction characters.
// ----------------------------------------------------------------------------
`default_nettype none

package btm_pkg;

    // default memory depths
    localparam int unsigned PROG_DEPTH_DEF = 4096;
    localparam int unsigned TAPE_DEPTH_DEF = 4096;

    // fixed field widths
    localparam int unsigned LOAD_ADDR_W = 12;
    localparam int unsigned BYTE_W      = 8;

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // run status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // instruction characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

    // request transaction
    typedef struct packed {
        logic [1:0]             req_type;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic [BYTE_W-1:0]      prog_char;
    } btm_req_t;

    // response transaction
    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic [1:0]        status;
    } btm_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/byte_tape_machine_step.sv */
// ----------------------------------------------------------------------------
// byte_tape_machine_step
// Step-wise interpreter for the eight-symbol byte tape language: program
// load, single-step execution with bracket scans, restart with tape clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its response shows
// on rsp for exactly one cycle with done high, and cannot be held off. A load
// or a reserved request answers in the cycle after it is taken, and busy stays
// low. A step that runs a plain instruction first reads the program and tape
// memories, then executes and writes the tape back. A bracket that jumps then
// scans the program memory for its partner, one read per cycle through a
// shared increment/decrement unit. A restart, and the time after reset, runs
// a clearing pass over all TAPE_DEPTH tape entries (4096 by default) with
// busy high; the restart response comes at its end, while the pass after
// reset ends without a response.
`default_nettype none

module byte_tape_machine_step #(
    parameter int unsigned TAPE_DEPTH = btm_pkg::TAPE_DEPTH_DEF,
    parameter int unsigned PROG_DEPTH = btm_pkg::PROG_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire btm_pkg::btm_req_t req,
    output logic                  done,
    output btm_pkg::btm_rsp_t     rsp
);

    import btm_pkg::*;

    localparam int unsigned PW  = $clog2(PROG_DEPTH);
    localparam int unsigned PCW = PW + 1;
    localparam int unsigned DW  = $clog2(TAPE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLEAR = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    // memories
    logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];

    // control and datapath registers
    logic [1:0]        state_reg,   state_next;
    logic [PCW-1:0]    pc_reg,      pc_next;
    logic [DW-1:0]     dp_reg,      dp_next;
    logic [1:0]        status_reg,  status_next;
    logic [PW-1:0]     pos_reg,     pos_next;
    logic [PCW-1:0]    level_reg,   level_next;
    logic              fwd_reg,     fwd_next;
    logic [DW-1:0]     clr_reg,     clr_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic              done_reg,    done_next;
    btm_rsp_t          rsp_reg,     rsp_next;
    logic [BYTE_W-1:0] prog_q_reg;
    logic [BYTE_W-1:0] tape_q_reg;

    // memory port controls
    logic              prog_we;
    logic [PW-1:0]     prog_waddr;
    logic [PW-1:0]     prog_raddr;
    logic              tape_we;
    logic [DW-1:0]     tape_waddr;
    logic [BYTE_W-1:0] tape_wdata;

    // shared scan step unit
    logic [PW-1:0]     step_base;
    logic              step_fwd;
    logic              step_edge;
    logic [PW-1:0]     step_addr;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // next scan address from the program counter or the scan position
    always_comb
    begin
        step_base = (state_reg == S_EXEC) ? pc_reg[PW-1:0] : pos_reg;
        step_fwd  = (state_reg == S_EXEC) ? (prog_q_reg == CH_OPEN) : fwd_reg;
        if (step_fwd)
        begin
            step_edge = (step_base == PW'(PROG_DEPTH - 1));
            step_addr = step_base + PW'(1);
        end
        else
        begin
            step_edge = (step_base == '0);
            step_addr = step_base - PW'(1);
        end
    end

    // sequencer
    always_comb
    begin
        logic lvl_up;
        logic lvl_dn;

        state_next   = state_reg;
        pc_next      = pc_reg;
        dp_next      = dp_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        level_next   = level_reg;
        fwd_next     = fwd_reg;
        clr_next     = clr_reg;
        clr_rsp_next = clr_rsp_reg;
        done_next    = 1'b0;
        rsp_next     = '0;
        prog_we      = 1'b0;
        prog_waddr   = PW'(req.load_addr);
        prog_raddr   = pc_reg[PW-1:0];
        tape_we      = 1'b0;
        tape_waddr   = dp_reg;
        tape_wdata   = tape_q_reg;
        lvl_up       = 1'b0;
        lvl_dn       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            prog_we   = (32'(req.load_addr) < PROG_DEPTH);
                            done_next = 1'b1;
                        end
                        REQ_STEP:
                        begin
                            if (status_reg != ST_RUN)
                            begin
                                done_next = 1'b1;
                            end
                            else if (pc_reg >= PCW'(PROG_DEPTH))
                            begin
                                status_next = ST_HALT;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        REQ_RESTART:
                        begin
                            dp_next      = '0;
                            pc_next      = '0;
                            status_next  = ST_RUN;
                            clr_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                tape_wdata = '0;
                clr_next   = clr_reg + DW'(1);
                if (clr_reg == DW'(TAPE_DEPTH - 1))
                begin
                    // only a restart request is answered, not the pass after reset
                    state_next   = S_IDLE;
                    done_next    = clr_rsp_reg;
                    clr_rsp_next = 1'b0;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (prog_q_reg == CH_NUL)
                begin
                    status_next = ST_HALT;
                end
                else
                begin
                    pc_next = pc_reg + PCW'(1);
                    unique case (prog_q_reg)
                        CH_RIGHT:
                        begin
                            dp_next = (dp_reg == DW'(TAPE_DEPTH - 1)) ? '0 : dp_reg + DW'(1);
                        end
                        CH_LEFT:
                        begin
                            dp_next = (dp_reg == '0) ? DW'(TAPE_DEPTH - 1) : dp_reg - DW'(1);
                        end
                        CH_INC:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_q_reg + 8'd1;
                        end
                        CH_DEC:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_q_reg - 8'd1;
                        end
                        CH_OUT:
                        begin
                            rsp_next.out_valid = 1'b1;
                            rsp_next.out_byte  = tape_q_reg;
                        end
                        CH_OPEN, CH_CLOSE:
                        begin
                            // jump taken: '[' on zero cell, ']' on nonzero cell
                            if ((prog_q_reg == CH_OPEN) == (tape_q_reg == '0))
                            begin
                                pc_next = pc_reg;
                                if (step_edge)
                                begin
                                    status_next = ST_ERR;
                                end
                                else
                                begin
                                    done_next  = 1'b0;
                                    pos_next   = step_addr;
                                    prog_raddr = step_addr;
                                    level_next = PCW'(1);
                                    fwd_next   = step_fwd;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                lvl_up = fwd_reg ? (prog_q_reg == CH_OPEN)  : (prog_q_reg == CH_CLOSE);
                lvl_dn = fwd_reg ? (prog_q_reg == CH_CLOSE) : (prog_q_reg == CH_OPEN);
                if (prog_q_reg == CH_NUL)
                begin
                    status_next = ST_ERR;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                end
                else if (lvl_dn && (level_reg == PCW'(1)))
                begin
                    // matching bracket found: resume after it
                    pc_next    = PCW'(pos_reg) + PCW'(1);
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (step_edge)
                begin
                    status_next = ST_ERR;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                end
                else
                begin
                    if (lvl_up)
                    begin
                        level_next = level_reg + PCW'(1);
                    end
                    else if (lvl_dn)
                    begin
                        level_next = level_reg - PCW'(1);
                    end
                    pos_next   = step_addr;
                    prog_raddr = step_addr;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.status = status_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pc_reg      <= '0;
            dp_reg      <= '0;
            status_reg  <= ST_RUN;
            level_reg   <= '0;
            fwd_reg     <= 1'b0;
            clr_reg     <= '0;
            clr_rsp_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            dp_reg      <= dp_next;
            status_reg  <= status_next;
            level_reg   <= level_next;
            fwd_reg     <= fwd_next;
            clr_reg     <= clr_next;
            clr_rsp_reg <= clr_rsp_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rsp_reg <= rsp_next;
    end

    // program memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_waddr] <= req.prog_char;
        end
        prog_q_reg <= prog_mem[prog_raddr];
    end

    // tape memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_q_reg <= tape_mem[dp_reg];
    end

    // checks
    a_out_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.out_valid |-> rsp_reg.status == ST_RUN)
        else $error("output byte reported with a stopped status");

    a_out_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !rsp_reg.out_valid |-> rsp_reg.out_byte == '0)
        else $error("out_byte nonzero without out_valid");

    a_dp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(dp_reg) < TAPE_DEPTH)
        else $error("data pointer beyond tape");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !done_reg)
        else $error("response during tape clear");

    a_scan_level: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> level_reg != '0)
        else $error("bracket scan with zero nesting level");

    a_exec_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(start) && $past(req.req_type) == REQ_STEP)
        else $error("execute without a step request");

endmodule

`default_nettype wire

/* tb/byte_tape_machine_step_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_tape_machine_step_tb
// Self-checking bench for the byte tape machine. Every program is closed by a
// NUL byte, so that no scan or step ever reads an unwritten entry. Directed
// tests cover pointer and cell wraps, output, bracket jumps, unmatched
// brackets and requests while stopped. Random tests load short programs,
// mostly with balanced brackets, and single step them with noise mixed in.
// A shadow interpreter predicts each response.
// ----------------------------------------------------------------------------

module byte_tape_machine_step_tb;

    import btm_pkg::*;

    localparam int unsigned PROG_DEPTH   = PROG_DEPTH_DEF;
    localparam int unsigned TAPE_DEPTH   = TAPE_DEPTH_DEF;
    localparam logic [1:0]  REQ_RESERVED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned CYCLE_LIMIT  = 20_000_000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    btm_req_t req;
    logic     done;
    btm_rsp_t rsp;

    // shadow machine state
    logic [7:0]  shadow_prog [PROG_DEPTH];
    logic [7:0]  shadow_tape [TAPE_DEPTH];
    logic [11:0] shadow_dp;
    int unsigned shadow_pc;
    logic [1:0]  shadow_status;

    btm_rsp_t    machine_rsp_q [$];
    int unsigned idle_pct;
    int unsigned item_count;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    byte_tape_machine_step dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // bracket partner search from the program counter
    function automatic bit find_partner(input bit fwd, output int unsigned match_pos);
        int unsigned pos;
        int unsigned level;
        logic [7:0]  ch;
        logic [7:0]  opener;
        logic [7:0]  closer;
        pos    = shadow_pc;
        level  = 1;
        opener = fwd ? CH_OPEN : CH_CLOSE;
        closer = fwd ? CH_CLOSE : CH_OPEN;
        match_pos = 0;
        while (level != 0)
        begin
            if (fwd)
            begin
                if (pos + 1 >= PROG_DEPTH)
                    return 1'b0;
                pos++;
            end
            else
            begin
                if (pos == 0)
                    return 1'b0;
                pos--;
            end
            ch = shadow_prog[pos];
            if (ch == CH_NUL)
                return 1'b0;
            if (ch == opener)
                level++;
            else if (ch == closer)
                level--;
        end
        match_pos = pos;
        return 1'b1;
    endfunction

    // apply one request to the shadow machine and give its response
    function automatic btm_rsp_t interpret_request(input btm_req_t r);
        btm_rsp_t    want;
        logic [7:0]  ch;
        logic [7:0]  cell_val;
        int unsigned target;
        bit          jump_ok;
        want = '0;
        case (r.req_type)
            REQ_LOAD:
                shadow_prog[r.load_addr] = r.prog_char;
            REQ_RESTART:
            begin
                foreach (shadow_tape[i])
                    shadow_tape[i] = 8'h00;
                shadow_dp     = '0;
                shadow_pc     = 0;
                shadow_status = ST_RUN;
            end
            REQ_STEP:
            begin
                if (shadow_status == ST_RUN)
                begin
                    if (shadow_pc >= PROG_DEPTH)
                        shadow_status = ST_HALT;
                    else
                    begin
                        ch       = shadow_prog[shadow_pc];
                        cell_val = shadow_tape[shadow_dp];
                        jump_ok  = 1'b1;
                        case (ch)
                            CH_NUL:   shadow_status = ST_HALT;
                            CH_RIGHT: shadow_dp = (shadow_dp == 12'(TAPE_DEPTH - 1)) ? '0
                                                  : shadow_dp + 12'd1;
                            CH_LEFT:  shadow_dp = (shadow_dp == '0) ? 12'(TAPE_DEPTH - 1)
                                                                    : shadow_dp - 12'd1;
                            CH_INC:   shadow_tape[shadow_dp] = cell_val + 8'd1;
                            CH_DEC:   shadow_tape[shadow_dp] = cell_val - 8'd1;
                            CH_OUT:
                            begin
                                want.out_valid = 1'b1;
                                want.out_byte  = cell_val;
                            end
                            CH_OPEN:
                            begin
                                if (cell_val == 8'h00)
                                begin
                                    jump_ok = find_partner(1'b1, target);
                                    if (jump_ok)
                                        shadow_pc = target;
                                end
                            end
                            CH_CLOSE:
                            begin
                                if (cell_val != 8'h00)
                                begin
                                    jump_ok = find_partner(1'b0, target);
                                    if (jump_ok)
                                        shadow_pc = target;
                                end
                            end
                            default: ;
                        endcase
                        // unmatched bracket leaves pc and tape alone
                        if (ch != CH_NUL)
                        begin
                            if (jump_ok)
                                shadow_pc++;
                            else
                                shadow_status = ST_ERR;
                        end
                    end
                end
            end
            default: ;
        endcase
        want.status = shadow_status;
        return want;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                     what, exp_val, act_val, cycle_count);
    endtask

    // response check, one transaction per done pulse
    always @(posedge clk)
    begin : rsp_check
        btm_rsp_t want;
        if (rst_n && done)
        begin
            if (machine_rsp_q.size() == 0)
                report_mismatch("unexpected response", 0, 1);
            else
            begin
                want = machine_rsp_q.pop_front();
                if (rsp.out_valid !== want.out_valid)
                    report_mismatch("out_valid", want.out_valid, rsp.out_valid);
                if (rsp.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, rsp.out_byte);
                if (rsp.status !== want.status)
                    report_mismatch("status", want.status, rsp.status);
            end
        end
    end

    // send one request transaction, with random idle cycles ahead of it
    task automatic send_req(input logic [1:0] kind, input logic [11:0] addr,
                            input logic [7:0] ch);
        btm_req_t item;
        item.req_type  = kind;
        item.load_addr = addr;
        item.prog_char = ch;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        machine_rsp_q.push_back(interpret_request(item));
        if (kind != REQ_RESERVED)
            item_count++;
    endtask

    task automatic send_step();
        send_req(REQ_STEP, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_restart();
        send_req(REQ_RESTART, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_reserved();
        send_req(REQ_RESERVED, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    endtask

    // program text at address 0, closed by a NUL
    task automatic load_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_req(REQ_LOAD, 12'(i), text[i]);
        send_req(REQ_LOAD, 12'(text.len()), CH_NUL);
    endtask

    task automatic step_until_stop(input int unsigned cap);
        int unsigned n;
        n = 0;
        while (shadow_status == ST_RUN && n < cap)
        begin
            send_step();
            n++;
        end
    endtask

    // moves, cell arithmetic, output, wraps, requests once halted
    task automatic test_plain_ops();
        send_restart();
        load_text("-.++.<-.>>.a");
        step_until_stop(20);
        send_step();
        send_reserved();
        send_req(REQ_LOAD, 12'd40, 8'hFF);
        send_step();
    endtask

    // skipped loop, counted loop, nested loops
    task automatic test_brackets();
        send_restart();
        load_text("[+]+[-.]>++[>+[-]<-].");
        step_until_stop(200);
    endtask

    // forward scan into a NUL, backward scan off the front, restart keeps program
    task automatic test_unmatched();
        send_restart();
        load_text("[");
        send_step();
        send_step();
        send_reserved();
        send_restart();
        send_step();
        send_restart();
        load_text("+]");
        step_until_stop(5);
    endtask

    // random programs single-stepped with noise
    task automatic test_random_programs();
        logic [7:0]  prog_buf [$];
        logic [7:0]  ch;
        int unsigned base_count;
        int unsigned len;
        int unsigned depth;
        int unsigned cap;
        int unsigned n;
        int unsigned after_stop;
        int unsigned pick;
        int unsigned run_idx;
        bit          well_formed;
        bit          restart_first;
        base_count = item_count;
        run_idx    = 0;
        while (item_count - base_count < RANDOM_ITEMS)
        begin
            // a stretch of back-to-back transactions now and then
            idle_pct = (run_idx % 6 == 2) ? 0 : 25;
            run_idx++;

            // build the program
            prog_buf.delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 16);
            well_formed = ($urandom_range(0, 99) < 85);
            depth = 0;
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    ch = CH_INC;
                else if (pick < 35)
                    ch = CH_DEC;
                else if (pick < 45)
                    ch = CH_RIGHT;
                else if (pick < 55)
                    ch = CH_LEFT;
                else if (pick < 67)
                    ch = CH_OUT;
                else if (pick < 79)
                    ch = CH_OPEN;
                else if (pick < 91)
                    ch = CH_CLOSE;
                else
                    ch = 8'($urandom_range(1, 255));
                if (well_formed)
                begin
                    if (ch == CH_OPEN)
                        depth++;
                    else if (ch == CH_CLOSE)
                    begin
                        if (depth == 0)
                            ch = CH_INC;
                        else
                            depth--;
                    end
                end
                prog_buf.push_back(ch);
            end
            while (well_formed && depth > 0)
            begin
                prog_buf.push_back(CH_CLOSE);
                depth--;
            end
            len = prog_buf.size();

            // load before or after the restart, ascending or descending
            restart_first = $urandom_range(0, 1);
            if (restart_first)
                send_restart();
            send_req(REQ_LOAD, 12'(len), CH_NUL);
            if ($urandom_range(0, 1))
            begin
                for (int i = 0; i < len; i++)
                    send_req(REQ_LOAD, 12'(i), prog_buf[i]);
            end
            else
            begin
                for (int i = len - 1; i >= 0; i--)
                    send_req(REQ_LOAD, 12'(i), prog_buf[i]);
            end
            if (!restart_first)
                send_restart();

            // run it, a few requests past the stop
            cap        = $urandom_range(10, 120);
            after_stop = $urandom_range(0, 2);
            n          = 0;
            while (n < cap)
            begin
                if (shadow_status != ST_RUN)
                begin
                    if (after_stop == 0)
                        break;
                    after_stop--;
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    send_reserved();
                else if (pick < 9)
                    send_req(REQ_LOAD, 12'($urandom_range(0, len - 1)),
                             8'($urandom_range(0, 255)));
                else if (pick < 10)
                    send_restart();
                else
                    send_step();
                n++;
            end
        end
    endtask

    // test sequence
    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req        <= '0;
        idle_pct   = 25;
        item_count = 0;
        shadow_dp     = '0;
        shadow_pc     = 0;
        shadow_status = ST_RUN;
        foreach (shadow_prog[i])
            shadow_prog[i] = 8'h00;
        foreach (shadow_tape[i])
            shadow_tape[i] = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_ops();
        test_brackets();
        test_unmatched();
        test_random_programs();

        // drain outstanding responses
        start <= 1'b0;
        while (machine_rsp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/btm_pkg.sv
rtl/core/byte_tape_machine_step.sv
tb/byte_tape_machine_step_tb.sv
